[rtl/core/kbt_pkg.sv]
// Shared types, constants and helpers for the kinematic bound tracker.
// Used by kbt_serial_mul, kbt_serial_div and st_kinematic_bound_tracker_core.
package kbt_pkg;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 33;

    localparam logic [1:0] OP_QUERY   = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_DECEL = 2'd1;
    localparam logic [1:0] CFG_SPEED = 2'd2;
    localparam logic [1:0] CFG_START = 2'd3;

    localparam logic [62:0] BIG_LIM = 63'h4000_0000_0000_0000;

    typedef logic signed [63:0] wide_t;
    typedef logic signed [65:0] ext_t;
    typedef logic signed [31:0] q_t;

    // Saturate a wide signed value to 32 bits.
    function automatic q_t sat32(input ext_t v);
        ext_t hi;
        ext_t lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic wide_t apply_sign(input logic [63:0] mag, input logic neg);
        return neg ? wide_t'(-mag) : wide_t'(mag);
    endfunction

    // Clamp a magnitude at 2^62.
    function automatic logic [62:0] clamp62(input logic [MUL_P_W-1:0] x);
        return (x > MUL_P_W'(BIG_LIM)) ? BIG_LIM : x[62:0];
    endfunction

endpackage

[rtl/core/st_kinematic_bound_tracker_core.sv]
// Kinematic bound tracker: top level with sequencer, anchors and output register.
// Depends on kbt_pkg, kbt_serial_mul and kbt_serial_div.
//
// Usage: the block holds a lower and an upper position anchor. Each input word
// (operation, query_time, lower_block_s, upper_block_s) returns one output word
// with both bounds at query_time, computed from the anchors as they stood before
// the word; an update re-anchors a bound that crossed its blocking position and
// a restart reloads both anchors from start_speed.
// Input and output use valid/ready; a word moves when both are high.
// The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while the block is idle.
// Sequence per word: all products run through one bit-serial multiplier (nine of
// them) and both quotients through one bit-serial divider; then ST_BOUND forms the
// bounds, and ST_UPD updates the anchors and loads the output register.
// in_ready is high only while the sequencer is idle; a finished word may still
// wait in the output register while the next word is taken in.
// When the receiver stalls, the output word holds and the next word waits in the
// final stage until the output register frees.
// Reset clears anchors to zero, loads register defaults and empties the output.
module st_kinematic_bound_tracker_core
    import kbt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic signed [31:0] query_time,
    input  logic signed [31:0] lower_block_s,
    input  logic signed [31:0] upper_block_s,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [31:0] lower_bound_s,
    output logic signed [31:0] upper_bound_s,
    output logic              lower_moved,
    output logic              upper_moved,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_BOUND = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    // Arithmetic steps, in issue order.
    localparam logic [3:0] STEP_P1  = 4'd0;   // decel * dt_lower
    localparam logic [3:0] STEP_PV  = 4'd1;   // v * dt_lower
    localparam logic [3:0] STEP_Q1  = 4'd2;   // braking quadratic term
    localparam logic [3:0] STEP_VV  = 4'd3;   // v * v
    localparam logic [3:0] STEP_QL  = 4'd4;   // stopping distance quotient
    localparam logic [3:0] STEP_P2  = 4'd5;   // accel * dt_upper
    localparam logic [3:0] STEP_PU  = 4'd6;   // u * dt_upper
    localparam logic [3:0] STEP_Q2  = 4'd7;   // accelerating quadratic term
    localparam logic [3:0] STEP_RR  = 4'd8;   // room * room
    localparam logic [3:0] STEP_QU  = 4'd9;   // ramp-up distance quotient
    localparam logic [3:0] STEP_PVM = 4'd10;  // dt_upper * max_speed

    localparam int QUAD_SHIFT = 2 * FRAC_BITS + 1;

    // Configuration registers
    logic [30:0] accel_reg, decel_reg, speed_reg, start_reg_cfg;

    // Anchors
    q_t lat_reg, lv_reg, lp_reg;
    q_t uat_reg, uv_reg, up_reg;

    // Latched input word
    logic [1:0] op_reg;
    q_t         t_reg, lblk_reg, ublk_reg;

    // Sequencer
    logic [1:0] state_reg;
    logic [3:0] step_reg;
    logic       start_reg;

    // Intermediate results
    wide_t       p1_reg, p1q_reg, pvq_reg, q1s_reg;
    wide_t       p2_reg, p2q_reg, puq_reg, q2s_reg, pvmq_reg;
    logic [63:0] sq_reg;
    logic [62:0] ql_reg, qu_reg;
    q_t          lb_reg, ub_reg;

    // Output register
    logic out_valid_reg;
    q_t   lower_bound_s_reg, upper_bound_s_reg;
    logic lower_moved_reg, upper_moved_reg;

    logic [30:0] md_eff, ma_eff;
    logic signed [32:0] dtl, dtu, room;

    logic signed [63:0] a_val;
    logic signed [33:0] b_val;
    logic [63:0]        a_mag;
    logic [33:0]        b_abs;
    logic               prod_neg;
    logic               is_div;
    logic               unit_done;

    logic               mul_done, div_done;
    logic [MUL_P_W-1:0] mul_prod;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_D_W-1:0] div_den;
    logic [63:0]        prod_q;
    logic [62:0]        prod_sq;

    logic  lower_brake, upper_accel;
    ext_t  lower_disp, upper_disp, lb_full, ub_full;
    ext_t  nvl, nvu;
    logic  lmove, umove, out_free;

    assign md_eff = (decel_reg == '0) ? 31'd1 : decel_reg;
    assign ma_eff = (accel_reg == '0) ? 31'd1 : accel_reg;

    assign dtl  = {t_reg[31], t_reg} - {lat_reg[31], lat_reg};
    assign dtu  = {t_reg[31], t_reg} - {uat_reg[31], uat_reg};
    assign room = {2'b00, speed_reg} - {uv_reg[31], uv_reg};

    // Operand select for the multiplier, by step
    always_comb
    begin
        a_val = '0;
        b_val = '0;
        case (step_reg)
            STEP_P1:
            begin
                a_val = {33'd0, md_eff};
                b_val = {dtl[32], dtl};
            end
            STEP_PV:
            begin
                a_val = {{32{lv_reg[31]}}, lv_reg};
                b_val = {dtl[32], dtl};
            end
            STEP_Q1:
            begin
                a_val = p1_reg;
                b_val = {dtl[32], dtl};
            end
            STEP_VV:
            begin
                a_val = {{32{lv_reg[31]}}, lv_reg};
                b_val = {{2{lv_reg[31]}}, lv_reg};
            end
            STEP_P2:
            begin
                a_val = {33'd0, ma_eff};
                b_val = {dtu[32], dtu};
            end
            STEP_PU:
            begin
                a_val = {{32{uv_reg[31]}}, uv_reg};
                b_val = {dtu[32], dtu};
            end
            STEP_Q2:
            begin
                a_val = p2_reg;
                b_val = {dtu[32], dtu};
            end
            STEP_RR:
            begin
                a_val = {{31{room[32]}}, room};
                b_val = {room[32], room};
            end
            STEP_PVM:
            begin
                a_val = {33'd0, speed_reg};
                b_val = {dtu[32], dtu};
            end
            default:
            begin
                a_val = '0;
                b_val = '0;
            end
        endcase
    end

    assign a_mag    = a_val[63] ? 64'(-a_val) : 64'(a_val);
    assign b_abs    = b_val[33] ? 34'(-b_val) : 34'(b_val);
    assign prod_neg = a_val[63] ^ b_val[33];

    assign is_div    = (step_reg == STEP_QL) || (step_reg == STEP_QU);
    assign unit_done = is_div ? div_done : mul_done;
    assign div_den   = (step_reg == STEP_QL) ? {1'b0, md_eff, 1'b0} : {1'b0, ma_eff, 1'b0};

    kbt_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg && !is_div),
        .a_mag (a_mag),
        .b_mag (b_abs[MUL_B_W-1:0]),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    kbt_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg && is_div),
        .dividend (sq_reg),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign prod_q  = mul_prod[63:0] >> FRAC_BITS;
    assign prod_sq = clamp62(mul_prod >> QUAD_SHIFT);

    // Bounds from the gathered terms
    assign lower_brake = p1_reg < ($signed({{32{lv_reg[31]}}, lv_reg}) <<< FRAC_BITS);
    assign upper_accel = p2_reg < ($signed({{31{room[32]}}, room}) <<< FRAC_BITS);

    assign lower_disp = lower_brake
        ? ({{2{pvq_reg[63]}}, pvq_reg} - {{2{q1s_reg[63]}}, q1s_reg})
        : ext_t'({3'b000, ql_reg});
    assign upper_disp = upper_accel
        ? ({{2{puq_reg[63]}}, puq_reg} + {{2{q2s_reg[63]}}, q2s_reg})
        : ({{2{pvmq_reg[63]}}, pvmq_reg} - ext_t'({3'b000, qu_reg}));

    assign lb_full = {{34{lp_reg[31]}}, lp_reg} + lower_disp;
    assign ub_full = {{34{up_reg[31]}}, up_reg} + upper_disp;

    // Anchor updates
    assign lmove = (op_reg == OP_UPDATE) && (lb_reg < lblk_reg);
    assign umove = (op_reg == OP_UPDATE) && (ub_reg > ublk_reg);
    assign nvl   = {{34{lv_reg[31]}}, lv_reg} - {{2{p1q_reg[63]}}, p1q_reg};
    assign nvu   = {{34{uv_reg[31]}}, uv_reg} + {{2{p2q_reg[63]}}, p2q_reg};

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_P1;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            accel_reg     <= 31'd65536;
            decel_reg     <= 31'd65536;
            speed_reg     <= 31'd655360;
            start_reg_cfg <= 31'd0;
            lat_reg       <= '0;
            lv_reg        <= '0;
            lp_reg        <= '0;
            uat_reg       <= '0;
            uv_reg        <= '0;
            up_reg        <= '0;
        end
        else
        begin
            // Pulse a unit start on accept and after each step but the last
            start_reg <= ((state_reg == ST_IDLE) && in_valid)
                      || ((state_reg == ST_CALC) && unit_done && (step_reg != STEP_PVM));

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ACCEL: accel_reg     <= cfg_data[30:0];
                    CFG_DECEL: decel_reg     <= cfg_data[30:0];
                    CFG_SPEED: speed_reg     <= cfg_data[30:0];
                    CFG_START: start_reg_cfg <= cfg_data[30:0];
                    default:   accel_reg     <= accel_reg;
                endcase
            end

            // Load a new output word, or drop the old one once taken
            if (state_reg == ST_UPD && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CALC;
                        step_reg  <= STEP_P1;
                    end
                end
                ST_CALC:
                begin
                    // Advance to the next step once the active unit finishes
                    if (unit_done)
                    begin
                        if (step_reg == STEP_PVM)
                            state_reg <= ST_BOUND;
                        else
                            step_reg  <= step_reg + 1'b1;
                    end
                end
                ST_BOUND:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (op_reg == OP_RESTART)
                        begin
                            lat_reg <= '0;
                            lv_reg  <= {1'b0, start_reg_cfg};
                            lp_reg  <= '0;
                            uat_reg <= '0;
                            uv_reg  <= {1'b0, start_reg_cfg};
                            up_reg  <= '0;
                        end
                        else
                        begin
                            if (lmove)
                            begin
                                lat_reg <= t_reg;
                                lp_reg  <= lblk_reg;
                                lv_reg  <= nvl[65] ? '0 : sat32(nvl);
                            end
                            if (umove)
                            begin
                                uat_reg <= t_reg;
                                up_reg  <= ublk_reg;
                                uv_reg  <= (nvu > ext_t'({35'd0, speed_reg}))
                                           ? {1'b0, speed_reg} : sat32(nvu);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: input latch, intermediate terms, output word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            t_reg    <= query_time;
            lblk_reg <= lower_block_s;
            ublk_reg <= upper_block_s;
        end

        if (state_reg == ST_CALC && unit_done)
        begin
            case (step_reg)
                STEP_P1:
                begin
                    p1_reg  <= apply_sign(mul_prod[63:0], prod_neg);
                    p1q_reg <= apply_sign(prod_q, prod_neg);
                end
                STEP_PV:  pvq_reg  <= apply_sign(prod_q, prod_neg);
                STEP_Q1:  q1s_reg  <= apply_sign({1'b0, prod_sq}, prod_neg);
                STEP_VV:  sq_reg   <= mul_prod[63:0];
                STEP_QL:  ql_reg   <= clamp62(MUL_P_W'(div_quo));
                STEP_P2:
                begin
                    p2_reg  <= apply_sign(mul_prod[63:0], prod_neg);
                    p2q_reg <= apply_sign(prod_q, prod_neg);
                end
                STEP_PU:  puq_reg  <= apply_sign(prod_q, prod_neg);
                STEP_Q2:  q2s_reg  <= apply_sign({1'b0, prod_sq}, prod_neg);
                STEP_RR:  sq_reg   <= mul_prod[63:0];
                STEP_QU:  qu_reg   <= clamp62(MUL_P_W'(div_quo));
                STEP_PVM: pvmq_reg <= apply_sign(prod_q, prod_neg);
                default:  sq_reg   <= sq_reg;
            endcase
        end

        if (state_reg == ST_BOUND)
        begin
            lb_reg <= sat32(lb_full);
            ub_reg <= sat32(ub_full);
        end

        if (state_reg == ST_UPD && out_free)
        begin
            lower_bound_s_reg <= lb_reg;
            upper_bound_s_reg <= ub_reg;
            lower_moved_reg   <= lmove;
            upper_moved_reg   <= umove;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign lower_bound_s = lower_bound_s_reg;
    assign upper_bound_s = upper_bound_s_reg;
    assign lower_moved   = lower_moved_reg;
    assign upper_moved   = upper_moved_reg;

    // Accepted word kicks off the first multiply
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CALC && start_reg && step_reg == STEP_P1))
        else $error("accepted word did not start the sequencer");

    // Units are only started while computing
    a_start_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == ST_CALC))
        else $error("unit start outside compute state");

    // Step counter stays within the program
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (step_reg <= STEP_PVM))
        else $error("step counter out of range");

    // Lower anchor speed is never negative
    a_lower_speed: assert property (@(posedge clk) disable iff (!rst_n)
        !lv_reg[31])
        else $error("lower anchor speed went negative");

endmodule

[rtl/core/kbt_serial_mul.sv]
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on kbt_pkg for operand widths.
module kbt_serial_mul
    import kbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a_mag,
    input  logic [MUL_B_W-1:0] b_mag,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_P_W-1:0] acc_next;
    logic [MUL_A_W:0]   sum;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // Add the multiplicand into the top half, then shift right one bit.
    assign sum = {1'b0, acc_reg[MUL_P_W-1:MUL_B_W]} + {1'b0, (b_reg[0] ? a_reg : '0)};
    assign acc_next = {sum, acc_reg[MUL_B_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(MUL_B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/core/kbt_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on kbt_pkg for operand widths.
module kbt_serial_div
    import kbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   trial;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // Keep the trial difference when it does not go negative.
            if (!trial[DIV_D_W])
            begin
                rem_reg <= trial[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
